/* sv/chv_pkg.sv */
// ----------------------------------------------------------------------------
// chv_pkg
// Shared constants, codes and stage structs of the container header validator.
// ----------------------------------------------------------------------------
package chv_pkg;

  localparam int unsigned HEADER_BYTES = 60;
  localparam int unsigned RECORD_BYTES = 48;

  localparam int unsigned MAGIC_W  = 32;
  localparam int unsigned VER_W    = 16;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned OFS_W    = 64;
  localparam int unsigned FSZ_W    = 63;
  localparam int unsigned COMP_W   = 32;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned VERD_W   = 2;
  localparam int unsigned ATB_W    = 38;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // full width of asset_count * RECORD_BYTES
  localparam int unsigned TBL_W = CNT_W + $clog2(RECORD_BYTES + 1);
  // section end, one carry bit above the offset width
  localparam int unsigned END_W = OFS_W + 1;

  localparam logic [1:0] ALIGN_MASK = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC = 2'd0,
    REG_MAJOR = 2'd1,
    REG_MINOR = 2'd2
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_MAGIC      = 4'd2,
    ST_VERSION    = 4'd3,
    ST_ALIGN      = 4'd4,
    ST_RESERVED   = 4'd5,
    ST_BEYOND_END = 4'd6,
    ST_OVERLAP    = 4'd7,
    ST_DATA_ALIGN = 4'd8
  } status_e;

  typedef enum logic [VERD_W-1:0] {
    VD_OK          = 2'd0,
    VD_MALFORMED   = 2'd1,
    VD_UNSUPPORTED = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [MAGIC_W-1:0] magic;
    logic [VER_W-1:0]   major;
    logic [VER_W-1:0]   minor;
  } cfg_t;

  // after stage A: early checks, table size and section ends
  typedef struct packed {
    logic              f_short;
    logic              f_magic;
    logic              f_version;
    logic              f_align;
    logic              f_reserved;
    logic              f_dalign_pre;
    logic [TBL_W-1:0]  tbl;
    logic [OFS_W-1:0]  ato;
    logic [OFS_W-1:0]  sto;
    logic [OFS_W-1:0]  dso;
    logic [FSZ_W-1:0]  fsz;
    logic [END_W-1:0]  s_end;
    logic [END_W-1:0]  d_end;
    logic [END_W-1:0]  r_end;
  } stage_a_t;

  // after stage B: string and data bounds settled, asset table end formed
  typedef struct packed {
    logic              f_short;
    logic              f_magic;
    logic              f_version;
    logic              f_align;
    logic              f_reserved;
    logic              f_dalign;
    logic              fit_sd;
    logic              col_sd;
    logic [TBL_W-1:0]  tbl;
    logic [OFS_W-1:0]  ato;
    logic [OFS_W-1:0]  sto;
    logic [OFS_W-1:0]  dso;
    logic [FSZ_W-1:0]  fsz;
    logic [END_W-1:0]  s_end;
    logic [END_W-1:0]  d_end;
    logic [END_W-1:0]  a_end;
  } stage_b_t;

endpackage

/* sv/container_header_validator_core.sv */
// ----------------------------------------------------------------------------
// container_header_validator_core
// Checks one decoded container header per transaction and reports a status,
// a verdict and the asset table size.
// ----------------------------------------------------------------------------
//  channel   direction  signals                                  handshake
//  command   in         start_i, header fields, file_size_i, ...  start_i & !busy_o
//  result    out        done_o, status_o, verdict_o, asset_...   done_o, one cycle
//  config    in         cfg_we_i, cfg_idx_i, cfg_data_i           cfg_we_i
//
//  One transaction is taken every cycle; done_o rises once the accepted
//  header has passed the three register stages (field checks and
//  products, section bounds, overlap and priority). busy_o stays low.
//  Reset clears the stage valid bits and loads the register defaults.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module container_header_validator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [chv_pkg::MAGIC_W-1:0]    magic_word_i,
  input  logic [chv_pkg::VER_W-1:0]      major_version_i,
  input  logic [chv_pkg::VER_W-1:0]      minor_version_i,
  input  logic [chv_pkg::CNT_W-1:0]      record_count_i,
  input  logic [chv_pkg::OFS_W-1:0]      asset_table_offset_i,
  input  logic [chv_pkg::OFS_W-1:0]      string_table_offset_i,
  input  logic [chv_pkg::OFS_W-1:0]      string_table_size_i,
  input  logic [chv_pkg::OFS_W-1:0]      data_section_offset_i,
  input  logic [chv_pkg::OFS_W-1:0]      data_section_size_i,
  input  logic [chv_pkg::OFS_W-1:0]      reserved_word_i,
  input  logic [chv_pkg::FSZ_W-1:0]      file_size_i,
  input  logic [chv_pkg::COMP_W-1:0]     first_compression_i,
  output logic                           done_o,
  output logic [chv_pkg::STATUS_W-1:0]   status_o,
  output logic [chv_pkg::VERD_W-1:0]     verdict_o,
  output logic [chv_pkg::ATB_W-1:0]      asset_table_bytes_o,
  input  logic                           cfg_we_i,
  input  logic [chv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [chv_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import chv_pkg::*;

  cfg_t     cfg_q;
  logic     accept;
  logic     valid_a, valid_b;
  stage_a_t data_a;
  stage_b_t data_b;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic <= '0;
      cfg_q.major <= VER_W'(1);
      cfg_q.minor <= '0;
    end else if (cfg_we_i) begin
      // drop writes to unknown indexes
      case (cfg_idx_i)
        REG_MAGIC: cfg_q.magic <= MAGIC_W'(cfg_data_i);
        REG_MAJOR: cfg_q.major <= cfg_data_i[VER_W-1:0];
        REG_MINOR: cfg_q.minor <= cfg_data_i[VER_W-1:0];
        default:   cfg_q       <= cfg_q;
      endcase
    end
  end

  chv_early u_early (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .valid_i               (accept),
    .cfg_i                 (cfg_q),
    .magic_word_i          (magic_word_i),
    .major_version_i       (major_version_i),
    .minor_version_i       (minor_version_i),
    .record_count_i        (record_count_i),
    .asset_table_offset_i  (asset_table_offset_i),
    .string_table_offset_i (string_table_offset_i),
    .string_table_size_i   (string_table_size_i),
    .data_section_offset_i (data_section_offset_i),
    .data_section_size_i   (data_section_size_i),
    .reserved_word_i       (reserved_word_i),
    .file_size_i           (file_size_i),
    .first_compression_i   (first_compression_i),
    .valid_o               (valid_a),
    .data_o                (data_a)
  );

  chv_bounds u_bounds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_a),
    .data_i  (data_a),
    .valid_o (valid_b),
    .data_o  (data_b)
  );

  chv_resolve u_resolve (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (valid_b),
    .data_i              (data_b),
    .done_o              (done_o),
    .status_o            (status_o),
    .verdict_o           (verdict_o),
    .asset_table_bytes_o (asset_table_bytes_o)
  );

  a_valid_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_b) && $past(valid_a, 2))
    else $error("result strobe without a transaction in flight");

  a_verdict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == ST_OK) == (verdict_o == VD_OK)))
    else $error("verdict and status disagree on success");

  a_verdict_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_VERSION) |-> (verdict_o == VD_UNSUPPORTED))
    else $error("version failure not reported as unsupported");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ST_DATA_ALIGN))
    else $error("status code out of range");

endmodule

/* sv/chv_early.sv */
// ----------------------------------------------------------------------------
// chv_early
// Stage A: field checks against the registers, table size product and the
// string, data and first-record end sums.
// ----------------------------------------------------------------------------
module chv_early (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  chv_pkg::cfg_t             cfg_i,
  input  logic [chv_pkg::MAGIC_W-1:0] magic_word_i,
  input  logic [chv_pkg::VER_W-1:0] major_version_i,
  input  logic [chv_pkg::VER_W-1:0] minor_version_i,
  input  logic [chv_pkg::CNT_W-1:0] record_count_i,
  input  logic [chv_pkg::OFS_W-1:0] asset_table_offset_i,
  input  logic [chv_pkg::OFS_W-1:0] string_table_offset_i,
  input  logic [chv_pkg::OFS_W-1:0] string_table_size_i,
  input  logic [chv_pkg::OFS_W-1:0] data_section_offset_i,
  input  logic [chv_pkg::OFS_W-1:0] data_section_size_i,
  input  logic [chv_pkg::OFS_W-1:0] reserved_word_i,
  input  logic [chv_pkg::FSZ_W-1:0] file_size_i,
  input  logic [chv_pkg::COMP_W-1:0] first_compression_i,
  output logic                      valid_o,
  output chv_pkg::stage_a_t         data_o
);
  import chv_pkg::*;

  logic     valid_q;
  stage_a_t data_d, data_q;

  always_comb begin
    data_d.f_short   = ({1'b0, file_size_i} < OFS_W'(HEADER_BYTES));
    data_d.f_magic   = (magic_word_i != cfg_i.magic);
    data_d.f_version = (major_version_i != cfg_i.major) ||
                       (minor_version_i != cfg_i.minor);
    data_d.f_align   = ((asset_table_offset_i[1:0] & ALIGN_MASK) != 2'b00) ||
                       ((data_section_offset_i[1:0] & ALIGN_MASK) != 2'b00) ||
                       ((string_table_offset_i[1:0] & ALIGN_MASK) != 2'b00) ||
                       ((string_table_size_i[1:0] & ALIGN_MASK) != 2'b00);
    data_d.f_reserved = (reserved_word_i != '0);
    data_d.f_dalign_pre = ((data_section_size_i[1:0] & ALIGN_MASK) != 2'b00) &&
                          (record_count_i != '0) && (first_compression_i == '0);
    data_d.tbl   = TBL_W'(record_count_i) * TBL_W'(RECORD_BYTES);
    data_d.ato   = asset_table_offset_i;
    data_d.sto   = string_table_offset_i;
    data_d.dso   = data_section_offset_i;
    data_d.fsz   = file_size_i;
    data_d.s_end = {1'b0, string_table_offset_i} + {1'b0, string_table_size_i};
    data_d.d_end = {1'b0, data_section_offset_i} + {1'b0, data_section_size_i};
    data_d.r_end = {1'b0, asset_table_offset_i} + END_W'(RECORD_BYTES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/chv_bounds.sv */
// ----------------------------------------------------------------------------
// chv_bounds
// Stage B: string and data sections against the file end and each other,
// first-record bound, asset table end sum.
// ----------------------------------------------------------------------------
module chv_bounds (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  chv_pkg::stage_a_t data_i,
  output logic              valid_o,
  output chv_pkg::stage_b_t data_o
);
  import chv_pkg::*;

  logic             valid_q;
  stage_b_t         data_d, data_q;
  logic [OFS_W-1:0] fsz_ext;
  logic             fit_s, fit_d, fit_r;

  always_comb begin
    fsz_ext = {1'b0, data_i.fsz};
    // a carry out of the end sum means the section wraps
    fit_s = !data_i.s_end[OFS_W] && (data_i.s_end[OFS_W-1:0] <= fsz_ext);
    fit_d = !data_i.d_end[OFS_W] && (data_i.d_end[OFS_W-1:0] <= fsz_ext);
    fit_r = !data_i.r_end[OFS_W] && (data_i.r_end[OFS_W-1:0] <= fsz_ext);

    data_d.f_short    = data_i.f_short;
    data_d.f_magic    = data_i.f_magic;
    data_d.f_version  = data_i.f_version;
    data_d.f_align    = data_i.f_align;
    data_d.f_reserved = data_i.f_reserved;
    data_d.f_dalign   = data_i.f_dalign_pre && fit_r;
    data_d.fit_sd     = fit_s && fit_d;
    data_d.col_sd     = data_i.s_end[OFS_W] || data_i.d_end[OFS_W] ||
                        ((data_i.sto < data_i.d_end[OFS_W-1:0]) &&
                         (data_i.dso < data_i.s_end[OFS_W-1:0]));
    data_d.tbl   = data_i.tbl;
    data_d.ato   = data_i.ato;
    data_d.sto   = data_i.sto;
    data_d.dso   = data_i.dso;
    data_d.fsz   = data_i.fsz;
    data_d.s_end = data_i.s_end;
    data_d.d_end = data_i.d_end;
    data_d.a_end = {1'b0, data_i.ato} + END_W'(data_i.tbl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/chv_resolve.sv */
// ----------------------------------------------------------------------------
// chv_resolve
// Stage C: asset table bound and overlaps, then first-failure priority and
// verdict, registered onto the result ports.
// ----------------------------------------------------------------------------
module chv_resolve (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  chv_pkg::stage_b_t           data_i,
  output logic                        done_o,
  output logic [chv_pkg::STATUS_W-1:0] status_o,
  output logic [chv_pkg::VERD_W-1:0]  verdict_o,
  output logic [chv_pkg::ATB_W-1:0]   asset_table_bytes_o
);
  import chv_pkg::*;

  logic             done_q;
  status_e          status_d, status_q;
  verdict_e         verdict_d, verdict_q;
  logic [ATB_W-1:0] atb_q;
  logic             fit_a, col_as, col_ad;

  always_comb begin
    fit_a  = !data_i.a_end[OFS_W] &&
             (data_i.a_end[OFS_W-1:0] <= {1'b0, data_i.fsz});
    col_as = data_i.a_end[OFS_W] || data_i.s_end[OFS_W] ||
             ((data_i.ato < data_i.s_end[OFS_W-1:0]) &&
              (data_i.sto < data_i.a_end[OFS_W-1:0]));
    col_ad = data_i.a_end[OFS_W] || data_i.d_end[OFS_W] ||
             ((data_i.ato < data_i.d_end[OFS_W-1:0]) &&
              (data_i.dso < data_i.a_end[OFS_W-1:0]));

    // first failure in file order wins
    if (data_i.f_short) begin
      status_d = ST_SHORT;
    end else if (data_i.f_magic) begin
      status_d = ST_MAGIC;
    end else if (data_i.f_version) begin
      status_d = ST_VERSION;
    end else if (data_i.f_align) begin
      status_d = ST_ALIGN;
    end else if (data_i.f_reserved) begin
      status_d = ST_RESERVED;
    end else if (!(fit_a && data_i.fit_sd)) begin
      status_d = ST_BEYOND_END;
    end else if (col_as || col_ad || data_i.col_sd) begin
      status_d = ST_OVERLAP;
    end else if (data_i.f_dalign) begin
      status_d = ST_DATA_ALIGN;
    end else begin
      status_d = ST_OK;
    end

    case (status_d)
      ST_OK:      verdict_d = VD_OK;
      ST_VERSION: verdict_d = VD_UNSUPPORTED;
      default:    verdict_d = VD_MALFORMED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      status_q  <= status_d;
      verdict_q <= verdict_d;
      atb_q     <= ATB_W'(data_i.tbl);
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign verdict_o           = verdict_q;
  assign asset_table_bytes_o = atb_q;

endmodule
